// File: sv/lcs_pkg.sv
package lcs_pkg;

   // Width of every input field; the solution and divisor result fields are one bit narrower.
   localparam int LCS_WIDTH = 32;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD_MOD = 2'd1,
      ST_NO_SOL  = 2'd2
   } lcs_status_type;

   typedef struct packed {
      logic signed [LCS_WIDTH-1:0] coefficient;
      logic signed [LCS_WIDTH-1:0] right_side;
      logic signed [LCS_WIDTH-1:0] modulus;
   } lcs_req_type;

   typedef struct packed {
      logic [LCS_WIDTH-2:0] solution;
      logic [LCS_WIDTH-2:0] divisor;
      lcs_status_type       status;
   } lcs_rsp_type;

endpackage

// File: sv/lcs_divider.sv
module lcs_divider #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-2:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-2:0] remainder
);

   localparam int N  = WIDTH - 1;
   localparam int CW = $clog2(WIDTH);
   localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [N-1:0]     rem_ff, rem_in;
   logic [N-1:0]     dvs_ff, dvs_in;
   logic [WIDTH-1:0] trial;
   logic [WIDTH-1:0] diff;
   logic             fits;

   // One restoring step per cycle: the dividend shifts out at the top while
   // the quotient bits shift in at the bottom of the same register.
   assign trial = {rem_ff, quo_ff[WIDTH-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = LAST;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[N-1:0] : trial[N-1:0];
         quo_in = {quo_ff[WIDTH-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: sv/lcs_modmul.sv
module lcs_modmul #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-2:0] x,
   input  logic [WIDTH-2:0] y,
   input  logic [WIDTH-2:0] m,
   output logic             done,
   output logic [WIDTH-2:0] product
);

   localparam int N  = WIDTH - 1;
   localparam int CW = $clog2(N);
   localparam logic [CW-1:0] LAST = CW'(N - 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic          add_ff, add_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [N-1:0]  acc_ff, acc_in;
   logic [N-1:0]  x_ff, x_in;
   logic [N-1:0]  y_ff, y_in;
   logic [N-1:0]  m_ff, m_in;
   logic [N-1:0]  operand;
   logic [N:0]    sum;
   logic [N:0]    diff;
   logic [N-1:0]  reduced;

   // A single adder with a modular correction serves both the doubling
   // phase and the conditional add phase of each multiplier bit.
   assign operand = add_ff ? x_ff : acc_ff;
   assign sum     = {1'b0, acc_ff} + {1'b0, operand};
   assign diff    = sum - {1'b0, m_ff};
   assign reduced = (sum >= {1'b0, m_ff}) ? diff[N-1:0] : sum[N-1:0];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      add_in  = add_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      m_in    = m_ff;
      if (start) begin
         busy_in = 1'b1;
         add_in  = 1'b0;
         cnt_in  = LAST;
         acc_in  = '0;
         x_in    = x;
         y_in    = y;
         m_in    = m;
      end else if (busy_ff) begin
         if (!add_ff) begin
            acc_in = reduced;
            add_in = 1'b1;
         end else begin
            if (y_ff[N-1]) begin
               acc_in = reduced;
            end
            y_in   = {y_ff[N-2:0], 1'b0};
            add_in = 1'b0;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      add_ff <= add_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      m_ff   <= m_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// File: sv/linear_congruence_solver.sv
// Steps: a bad modulus goes straight to its result; otherwise the coefficient and the
// right side are reduced mod d, each Euclid step takes one division and one modular
// product, and a division checks that the gcd divides b before the final product.
// Flow: one item at a time; req_stall is high while the serial divider and the serial
// modular multiplier work on the current item and until its result has moved out.
// Reset: synchronous, active high; the sequencer goes idle and no result is pending.
module linear_congruence_solver (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  lcs_pkg::lcs_req_type req_item,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output lcs_pkg::lcs_rsp_type rsp_item
);

   import lcs_pkg::*;

   localparam int W = LCS_WIDTH;
   localparam int N = W - 1;

   // Sequencer states. Every state that waits on a unit holds until that
   // unit pulses done; the shared units are started on the transition.
   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_RED_A  = 9'b000000010,
      S_RED_B  = 9'b000000100,
      S_EU_DIV = 9'b000001000,
      S_EU_MUL = 9'b000010000,
      S_CHK    = 9'b000100000,
      S_FIN    = 9'b001000000,
      S_DONE   = 9'b010000000,
      S_SPARE  = 9'b100000000
   } state_type;

   state_type   state_ff, state_in;
   logic [W-1:0] b_ff, b_in;
   logic        a_neg_ff, a_neg_in;
   logic [N-1:0] d_ff, d_in;
   logic [N-1:0] rb_ff, rb_in;
   logic [N-1:0] u_ff, u_in;
   logic [N-1:0] w_ff, w_in;
   logic [N-1:0] r_ff, r_in;
   logic [N-1:0] c1_ff, c1_in;
   logic [N-1:0] c2_ff, c2_in;
   lcs_rsp_type res_ff, res_in;
   lcs_rsp_type rsp_item_ff, rsp_item_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic         div_start;
   logic [W-1:0] div_dividend;
   logic [N-1:0] div_divisor;
   logic         div_done;
   logic [W-1:0] div_quo;
   logic [N-1:0] div_rem;

   logic         mul_start;
   logic [N-1:0] mul_x;
   logic [N-1:0] mul_y;
   logic         mul_done;
   logic [N-1:0] mul_prod;

   logic [N-1:0] q_mod;
   logic [N-1:0] c_next;

   // Magnitude of a two's complement word; the most negative value maps to
   // the sign weight itself, which still fits the unsigned width.
   function automatic logic [W-1:0] magnitude(input logic [W-1:0] v);
      magnitude = v[W-1] ? (~v + 1'b1) : v;
   endfunction

   // Turns the remainder of a magnitude into the non-negative residue of the
   // signed value: a negative operand with a nonzero remainder gives d - r.
   function automatic logic [N-1:0] residue(input logic neg, input logic [N-1:0] r,
                                            input logic [N-1:0] m);
      residue = (neg && (r != '0)) ? (m - r) : r;
   endfunction

   // In the Euclid loop the quotient never exceeds d, and equals d only when
   // the divisor is one; reducing it mod d is therefore a single compare.
   assign q_mod = (div_quo == {1'b0, d_ff}) ? '0 : div_quo[N-1:0];

   // New Bezout coefficient c1 - q*c2 mod d; the wraparound of the
   // subtraction is undone by adding d back when c1 is the smaller one.
   assign c_next = (c1_ff - mul_prod) + ((c1_ff < mul_prod) ? d_ff : '0);

   always_comb begin
      state_in     = state_ff;
      b_in         = b_ff;
      a_neg_in     = a_neg_ff;
      d_in         = d_ff;
      rb_in        = rb_ff;
      u_in         = u_ff;
      w_in         = w_ff;
      r_in         = r_ff;
      c1_in        = c1_ff;
      c2_in        = c2_ff;
      res_in       = res_ff;
      div_start    = 1'b0;
      div_dividend = {1'b0, u_ff};
      div_divisor  = w_ff;
      mul_start    = 1'b0;
      mul_x        = c1_ff;
      mul_y        = c2_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               b_in     = req_item.right_side;
               a_neg_in = req_item.coefficient[W-1];
               d_in     = req_item.modulus[N-1:0];
               if (req_item.modulus[W-1] || (req_item.modulus == '0)) begin
                  res_in.solution = '0;
                  res_in.divisor  = '0;
                  res_in.status   = ST_BAD_MOD;
                  state_in        = S_DONE;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = magnitude(req_item.coefficient);
                  div_divisor  = req_item.modulus[N-1:0];
                  state_in     = S_RED_A;
               end
            end
         end

         S_RED_A: begin
            if (div_done) begin
               // Euclid starts on (residue of a, d) with coefficients (1 mod d, 0).
               u_in         = residue(a_neg_ff, div_rem, d_ff);
               w_in         = d_ff;
               c1_in        = (d_ff == N'(1)) ? '0 : N'(1);
               c2_in        = '0;
               div_start    = 1'b1;
               div_dividend = magnitude(b_ff);
               div_divisor  = d_ff;
               state_in     = S_RED_B;
            end
         end

         S_RED_B: begin
            if (div_done) begin
               rb_in        = residue(b_ff[W-1], div_rem, d_ff);
               div_start    = 1'b1;
               div_dividend = {1'b0, u_ff};
               div_divisor  = w_ff;
               state_in     = S_EU_DIV;
            end
         end

         S_EU_DIV: begin
            if (div_done) begin
               r_in      = div_rem;
               mul_start = 1'b1;
               mul_x     = q_mod;
               mul_y     = c2_ff;
               state_in  = S_EU_MUL;
            end
         end

         S_EU_MUL: begin
            if (mul_done) begin
               u_in      = w_ff;
               w_in      = r_ff;
               c1_in     = c2_ff;
               c2_in     = c_next;
               div_start = 1'b1;
               if (r_ff == '0) begin
                  // The gcd is now w; test whether it divides the residue of b.
                  div_dividend = {1'b0, rb_ff};
                  div_divisor  = w_ff;
                  state_in     = S_CHK;
               end else begin
                  div_dividend = {1'b0, w_ff};
                  div_divisor  = r_ff;
                  state_in     = S_EU_DIV;
               end
            end
         end

         S_CHK: begin
            if (div_done) begin
               if (div_rem != '0) begin
                  res_in.solution = '0;
                  res_in.divisor  = u_ff;
                  res_in.status   = ST_NO_SOL;
                  state_in        = S_DONE;
               end else begin
                  // The quotient is at most the residue of b, so it is below d.
                  mul_start = 1'b1;
                  mul_x     = c1_ff;
                  mul_y     = div_quo[N-1:0];
                  state_in  = S_FIN;
               end
            end
         end

         S_FIN: begin
            if (mul_done) begin
               res_in.solution = mul_prod;
               res_in.divisor  = u_ff;
               res_in.status   = ST_OK;
               state_in        = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The output register frees the sequencer: a finished item moves out of
   // the working state as soon as the previous item has been taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      if ((state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_ff        <= b_in;
      a_neg_ff    <= a_neg_in;
      d_ff        <= d_in;
      rb_ff       <= rb_in;
      u_ff        <= u_in;
      w_ff        <= w_in;
      r_ff        <= r_in;
      c1_ff       <= c1_in;
      c2_ff       <= c2_in;
      res_ff      <= res_in;
      rsp_item_ff <= rsp_item_in;
   end

   lcs_divider #(
      .WIDTH (W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   lcs_modmul #(
      .WIDTH (W)
   ) u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .x       (mul_x),
      .y       (mul_y),
      .m       (d_ff),
      .done    (mul_done),
      .product (mul_prod)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef ASSERT_OFF
   // Bezout coefficients stay reduced below the modulus throughout the loop.
   a_coef_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EU_MUL) |-> ((c1_ff < d_ff) && (c2_ff < d_ff)))
      else $error("Bezout coefficient not reduced mod d");

   // A solved item carries a solution below the modulus and a nonzero gcd.
   a_solution_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE) && (res_ff.status == ST_OK)) |->
      ((res_ff.solution < d_ff) && (res_ff.divisor != '0)))
      else $error("solved item out of range");

   // An unsolvable item still reports a real gcd.
   a_nosol_gcd: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE) && (res_ff.status == ST_NO_SOL)) |-> (res_ff.divisor != '0))
      else $error("no-solution item with zero gcd");

   // An accepted item always starts work on the next cycle.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("accepted item did not start");
`endif

endmodule
